@@ rtl/lkvc_pkg.sv @@
package lkvc_pkg;

    localparam logic CMD_GET = 1'b0;
    localparam logic CMD_PUT = 1'b1;

    localparam logic signed [31:0] MISS_VALUE = -32'sd1;

    localparam logic [4:0] CAPACITY_RESET = 5'd16;

    typedef struct packed {
        logic               command;
        logic signed [31:0] lookup_key;
        logic signed [31:0] store_value;
    } req_t;

    typedef struct packed {
        logic               found;
        logic signed [31:0] read_value;
    } rsp_t;

    // one stored pair, as handed from a cell to its neighbor
    typedef struct packed {
        logic               valid;
        logic signed [31:0] key;
        logic signed [31:0] value;
    } entry_t;

    // broadcast to every cell of the chain
    typedef struct packed {
        logic               apply;
        logic signed [31:0] key;
        logic signed [31:0] value;
    } update_t;

endpackage

@@ rtl/lkvc_cell.sv @@
module lkvc_cell #(
    parameter int CNT_W = 5,
    parameter int INDEX = 0
) (
    input  logic              clk,
    input  logic              rst_n,
    input  lkvc_pkg::update_t upd,
    input  logic [CNT_W-1:0]  sel_m,
    input  lkvc_pkg::entry_t  prev,
    output lkvc_pkg::entry_t  cur,
    output logic              match
);
    import lkvc_pkg::*;

    logic               valid_reg;
    logic signed [31:0] key_reg;
    logic signed [31:0] value_reg;
    logic               shift;

    assign shift = upd.apply && (CNT_W'(INDEX) <= sel_m);
    assign match = valid_reg && (key_reg == upd.key);

    assign cur.valid = valid_reg;
    assign cur.key   = key_reg;
    assign cur.value = value_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (shift)
        begin
            valid_reg <= 1'b1;
        end
    end

    // front cell takes the new item, the others take their neighbor's pair
    always_ff @(posedge clk)
    begin
        if (shift)
        begin
            if (INDEX == 0)
            begin
                key_reg   <= upd.key;
                value_reg <= upd.value;
            end
            else
            begin
                key_reg   <= prev.key;
                value_reg <= prev.value;
            end
        end
    end

endmodule

@@ rtl/lkvc_chain.sv @@
module lkvc_chain #(
    parameter int ENTRIES = 16,
    parameter int CNT_W   = 5
) (
    input  logic               clk,
    input  logic               rst_n,
    input  lkvc_pkg::update_t  upd,
    input  logic [CNT_W-1:0]   sel_m,
    output logic               hit,
    output logic [CNT_W-1:0]   hit_idx,
    output logic signed [31:0] hit_value
);
    import lkvc_pkg::*;

    entry_t             ent   [ENTRIES];
    logic [ENTRIES-1:0] match;

    for (genvar i = 0; i < ENTRIES; i++)
    begin : g_cell
        entry_t prev;
        if (i == 0)
        begin : g_front
            assign prev = '0;
        end
        else
        begin : g_rest
            assign prev = ent[i-1];
        end

        lkvc_cell #(
            .CNT_W (CNT_W),
            .INDEX (i)
        ) u_cell (
            .clk   (clk),
            .rst_n (rst_n),
            .upd   (upd),
            .sel_m (sel_m),
            .prev  (prev),
            .cur   (ent[i]),
            .match (match[i])
        );
    end

    // valid keys are distinct, so at most one cell matches
    always_comb
    begin
        hit_idx   = '0;
        hit_value = '0;
        for (int i = 0; i < ENTRIES; i++)
        begin
            hit_idx   = hit_idx | (match[i] ? CNT_W'(i) : '0);
            hit_value = hit_value | (match[i] ? ent[i].value : '0);
        end
    end

    assign hit = |match;

endmodule

@@ rtl/lru_key_value_cache.sv @@
// Key-value store with least-recently-used replacement, ENTRIES pairs deep.
//
// Request channel (req_valid / req_stall / req): get or put. An item is taken
// when req_valid is high and req_stall is low. Response channel (rsp_valid /
// rsp_stall / rsp): one item per get, none per put.
//
// Pairs sit in a chain of cells ordered by recency, front cell most recent.
// After an item is taken into the request register, its key is compared in
// every cell at once; on a put or a get that hits, the chain shifts by one
// position up to the hit, the evicted or the newly filled cell, with the item loaded at the front.
// A get's response is valid the cycle after its compare, from the response
// register.
// A new item is taken only once the last has left the request register,
// which is held while the compare-and-shift runs and holds longer while a
// get waits for a stalled response register.
//
// Reset empties the store and sets capacity_reg to 16. cfg_we writes the
// capacity (0 acts as 1, values above ENTRIES act as ENTRIES). While rsp is
// stalled the response holds and the next get waits in the request register.
module lru_key_value_cache #(
    parameter int ENTRIES = 16
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_stall,
    input  lkvc_pkg::req_t req,
    output logic           rsp_valid,
    input  logic           rsp_stall,
    output lkvc_pkg::rsp_t rsp,
    input  logic           cfg_we,
    input  logic [4:0]     cfg_wdata
);
    import lkvc_pkg::*;

    localparam int CNT_W = $clog2(ENTRIES + 1);
    localparam int CMP_W = (CNT_W > 5) ? CNT_W : 5;

    logic             busy_reg;
    req_t             req_reg;
    logic             rsp_valid_reg;
    rsp_t             rsp_reg;
    logic [4:0]       capacity_reg;
    logic [CNT_W-1:0] occ_reg;
    logic [CNT_W-1:0] occ_next;

    logic               accept;
    logic               process;
    logic               is_put;
    logic               hit;
    logic [CNT_W-1:0]   hit_idx;
    logic signed [31:0] hit_value;
    logic [CMP_W-1:0]   cap_eff;
    logic               evict;
    logic [CNT_W-1:0]   sel_m;
    update_t            upd;

    assign accept    = req_valid && !busy_reg;
    assign req_stall = busy_reg;
    assign is_put    = (req_reg.command == CMD_PUT);
    assign process   = busy_reg && (is_put || !rsp_valid_reg || !rsp_stall);

    always_comb
    begin
        cap_eff = CMP_W'(capacity_reg);
        if (cap_eff == '0)
        begin
            cap_eff = CMP_W'(1);
        end
        else if (cap_eff > CMP_W'(ENTRIES))
        begin
            cap_eff = CMP_W'(ENTRIES);
        end
    end

    assign evict = CMP_W'(occ_reg) >= cap_eff;

    // last cell that moves: the hit, the least recent, or the first empty one
    always_comb
    begin
        if (hit)
        begin
            sel_m = hit_idx;
        end
        else if (evict)
        begin
            sel_m = occ_reg - CNT_W'(1);
        end
        else
        begin
            sel_m = occ_reg;
        end
    end

    assign upd.apply = process && (is_put || hit);
    assign upd.key   = req_reg.lookup_key;
    assign upd.value = is_put ? req_reg.store_value : hit_value;

    assign occ_next = (process && is_put && !hit && !evict) ? occ_reg + CNT_W'(1) : occ_reg;

    lkvc_chain #(
        .ENTRIES (ENTRIES),
        .CNT_W   (CNT_W)
    ) u_chain (
        .clk       (clk),
        .rst_n     (rst_n),
        .upd       (upd),
        .sel_m     (sel_m),
        .hit       (hit),
        .hit_idx   (hit_idx),
        .hit_value (hit_value)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            rsp_valid_reg <= 1'b0;
            capacity_reg  <= CAPACITY_RESET;
            occ_reg       <= '0;
        end
        else
        begin
            if (accept)
            begin
                busy_reg <= 1'b1;
            end
            else if (process)
            begin
                busy_reg <= 1'b0;
            end

            if (process && !is_put)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end

            if (cfg_we)
            begin
                capacity_reg <= cfg_wdata;
            end

            occ_reg <= occ_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg <= req;
        end
        if (process && !is_put)
        begin
            rsp_reg.found      <= hit;
            rsp_reg.read_value <= hit ? hit_value : MISS_VALUE;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

@@ rtl/lkvc_checker.sv @@
module lkvc_checker (
    input logic           clk,
    input logic           rst_n,
    input logic           req_valid,
    input logic           req_stall,
    input lkvc_pkg::req_t req,
    input logic           rsp_valid,
    input logic           rsp_stall,
    input lkvc_pkg::rsp_t rsp
);
    import lkvc_pkg::*;

    logic take;
    assign take = req_valid && !req_stall;

    // hold a stalled response
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
        else $error("stalled response changed");

    // one item in flight: never two takes in a row
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        take |=> req_stall)
        else $error("request taken while busy");

    // a put raises no new response
    a_put_silent: assert property (@(posedge clk) disable iff (!rst_n)
        take && (req.command == CMD_PUT) |-> ##2 (!rsp_valid || $past(rsp_valid && rsp_stall)))
        else $error("put produced a response");

    // a get taken while no response is valid raises a response
    a_get_answers: assert property (@(posedge clk) disable iff (!rst_n)
        take && (req.command == CMD_GET) && !rsp_valid |-> ##2 rsp_valid)
        else $error("get response missing");

    a_miss_value: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp.found |-> rsp.read_value == MISS_VALUE)
        else $error("miss did not return minus one");

endmodule

bind lru_key_value_cache lkvc_checker u_lkvc_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
);
